FILE: rtl/cldq_pkg.sv
// Shared types and codes for the circular deque with search.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cldq_pkg;

   // Operation codes carried in the request tuser
   typedef enum logic [1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_TAIL  = 2'd1,
      OP_POP       = 2'd2,
      OP_SEARCH    = 2'd3
   } opcode_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SRCH,
      S_HEAD,
      S_LOAD
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic latch;       // capture request fields
      logic exec;        // apply the operation to head, count and store
      logic srch_issue;  // read the next search entry
      logic head_issue;  // read the head entry
      logic load_out;    // load the result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic srch_needed; // search on a non-empty store
      logic srch_last;   // current search read is the last valid entry
      logic out_free;    // result register can take a new result
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/cldq_ctrl.sv
// Sequencing state machine for the circular deque.
// Depends on cldq_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module cldq_ctrl
   import cldq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = sts.srch_needed ? S_SRCH : S_HEAD;
         end
         S_SRCH: begin
            if (sts.srch_last) state_in = S_HEAD;
         end
         S_HEAD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_SRCH: begin
            cmd.srch_issue = 1'b1;
         end
         S_HEAD: begin
            cmd.head_issue = 1'b1;
         end
         S_LOAD: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/cldq_dpath.sv
// Datapath of the circular deque: ring store, head and count, search compare
// and the result register. Depends on cldq_pkg; driven by cldq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cldq_dpath
   import cldq_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int IDX_W  = $clog2(DEPTH),
   parameter int CNT_W  = $clog2(DEPTH + 1),
   parameter int RSP_W  = ((35 + CNT_W + 7) / 8) * 8
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic [1:0]        req_tuser,
   input  wire logic [31:0]       req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata
);

   localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   // Add an offset to a ring index and wrap once
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_X) sum = sum - DEPTH_X;
      return sum[IDX_W-1:0];
   endfunction

   opcode_type       op_ff;
   logic [31:0]      value_ff;
   logic [IDX_W-1:0] head_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] srch_idx_ff;
   logic [31:0]      rd_data_ff;
   logic             rd_vld_ff;
   logic             found_ff;
   status_type       status_ff;
   logic             rsp_valid_ff;
   logic [31:0]      rsp_head_ff;
   logic             rsp_found_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   status_type       rsp_status_ff;

   logic [31:0]      mem [DEPTH];

   logic             full;
   logic             empty;
   logic [IDX_W-1:0] head_dec;
   logic [IDX_W-1:0] tail_pos;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] rd_addr;

   assign full     = (count_ff == DEPTH_C);
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign tail_pos = ring_add(head_ff, count_ff[IDX_W-1:0]);

   // Store write on an insert that fits
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = tail_pos;
      if (cmd.exec && !full) begin
         if (op_ff == OP_INS_FRONT) begin
            mem_we    = 1'b1;
            mem_waddr = head_dec;
         end else if (op_ff == OP_INS_TAIL) begin
            mem_we    = 1'b1;
         end
      end
   end

   assign rd_addr = cmd.head_issue ? head_ff : ring_add(head_ff, srch_idx_ff);

   // Ring store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= value_ff;
      if (cmd.srch_issue || cmd.head_issue) rd_data_ff <= mem[rd_addr];
   end

   // Capture the request fields
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= opcode_type'(req_tuser);
         value_ff <= req_tdata;
      end
   end

   // Apply the operation to head and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         case (op_ff)
            OP_INS_FRONT: begin
               if (!full) begin
                  head_ff  <= head_dec;
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            OP_INS_TAIL: begin
               if (!full) count_ff <= count_ff + CNT_W'(1);
            end
            OP_POP: begin
               if (!empty) begin
                  head_ff  <= ring_add(head_ff, IDX_W'(1));
                  count_ff <= count_ff - CNT_W'(1);
               end
            end
            default: begin
               head_ff <= head_ff;
            end
         endcase
      end
   end

   // Status of the current operation
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= ST_OK;
         case (op_ff)
            OP_INS_FRONT, OP_INS_TAIL: begin
               if (full) status_ff <= ST_FULL;
            end
            OP_POP, OP_SEARCH: begin
               if (empty) status_ff <= ST_EMPTY;
            end
            default: begin
               status_ff <= ST_OK;
            end
         endcase
      end
   end

   // Advance the search walk and compare each entry as it returns
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         srch_idx_ff <= '0;
      end else begin
         rd_vld_ff <= cmd.srch_issue;
         if (cmd.exec) begin
            srch_idx_ff <= '0;
            found_ff    <= 1'b0;
         end else begin
            if (cmd.srch_issue) srch_idx_ff <= srch_idx_ff + IDX_W'(1);
            if (rd_vld_ff && (rd_data_ff == value_ff)) found_ff <= 1'b1;
         end
      end
   end

   assign sts.srch_needed = (op_ff == OP_SEARCH) && !empty;
   assign sts.srch_last   = (CNT_W'(srch_idx_ff) + CNT_W'(1)) == count_ff;
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   // Result register: load on command, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_head_ff   <= empty ? 32'd0 : rd_data_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   // Pack the result, zero-filled up to the byte boundary
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_status_ff, rsp_count_ff, rsp_found_ff, rsp_head_ff});

endmodule

`default_nettype wire

FILE: rtl/circular_list_deque_with_search.sv
// Bounded circular deque of signed 32-bit values with a linear search.
// Request channel (req_): tuser carries the opcode (insert front, insert
//   tail, pop head, search), tdata the value to insert or search for.
// Response channel (rsp_): one transfer per request with the head value
//   (zero when empty), a found flag, the element count and a status code
//   (ok, empty on pop or search, full on insert).
// Sequence: a request is captured in idle and applied in exec; a search then
//   reads one ring entry per cycle through the single store read port; the
//   head entry is read and the result register is loaded. One request is in
//   work at a time; a new request is taken in the cycle after the previous
//   one has reached the result register.
// Reset empties the deque (head and count cleared); store contents are not
//   cleared and need no clearing pass.
// A stalled response holds in the result register; the block finishes the
//   next request up to that register and then waits for rsp_tready.
// Depends on cldq_pkg, cldq_ctrl and cldq_dpath.
`timescale 1ns / 1ps
`default_nettype none

module circular_list_deque_with_search
   import cldq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int RSP_W = ((35 + CNT_W + 7) / 8) * 8
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [1:0]       req_tuser,   // [1:0] opcode
   input  wire logic [31:0]      req_tdata,   // [31:0] value
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata    // head_value, found, count, status, zero pad
);

   cmd_type cmd;
   sts_type sts;

   cldq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cldq_dpath #(
      .DEPTH (DEPTH),
      .IDX_W ($clog2(DEPTH)),
      .CNT_W (CNT_W),
      .RSP_W (RSP_W)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: bench/cldq_result_check.sv
// Response checker for the circular deque with search: tracks deque state from
// request transfers, predicts each response and compares it field by field.
// Depends on cldq_pkg for the opcode and status codes.
`timescale 1ns / 1ps

module cldq_result_check
   import cldq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int RSP_W = ((35 + CNT_W + 7) / 8) * 8
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [1:0]       req_tuser,   // [1:0] opcode
   input  wire logic [31:0]      req_tdata,   // [31:0] value
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,   // head_value, found, count, status
   output int unsigned           mismatch_count,
   output int unsigned           outstanding
);

   typedef struct {
      logic signed [31:0] head_value;
      logic               found;
      logic [CNT_W-1:0]   count;
      status_type         status;
   } deque_rsp_type;

   // Shadow copy of the ring and its pointers
   logic signed [31:0] ring_data [DEPTH];
   int unsigned        front_pos;
   int unsigned        fill_level;

   deque_rsp_type queued_results [$];
   int unsigned   error_total = 0;
   int unsigned   waiting = 0;

   assign mismatch_count = error_total;
   assign outstanding    = waiting;

   // Apply one operation to the shadow ring and return the response it gives
   function automatic deque_rsp_type deque_update(opcode_type op, logic signed [31:0] val);
      deque_rsp_type r;
      int unsigned   i;
      r.found  = 1'b0;
      r.status = ST_OK;
      case (op)
         OP_INS_FRONT: begin
            if (fill_level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               front_pos = (front_pos + DEPTH - 1) % DEPTH;
               ring_data[front_pos] = val;
               fill_level++;
            end
         end
         OP_INS_TAIL: begin
            if (fill_level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               ring_data[(front_pos + fill_level) % DEPTH] = val;
               fill_level++;
            end
         end
         OP_POP: begin
            if (fill_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               front_pos = (front_pos + 1) % DEPTH;
               fill_level--;
            end
         end
         default: begin
            // scan every valid entry, tail included
            if (fill_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (i = 0; i < fill_level; i++)
                  if (ring_data[(front_pos + i) % DEPTH] == val) r.found = 1'b1;
            end
         end
      endcase
      r.head_value = (fill_level == 0) ? 32'sd0 : ring_data[front_pos];
      r.count      = CNT_W'(fill_level);
      return r;
   endfunction

   function automatic void compare_field(string field, longint expv, longint actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
         error_total++;
      end
   endfunction

   // Sample both channels at the rising edge; drain responses before new requests
   always @(posedge clock) begin : watch_channels
      deque_rsp_type exp_rsp;
      if (reset) begin
         front_pos  = 0;
         fill_level = 0;
         queued_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (queued_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %h", $time, rsp_tdata);
               error_total++;
            end else begin
               exp_rsp = queued_results.pop_front();
               compare_field("head_value", exp_rsp.head_value,
                             $signed(rsp_tdata[31:0]));
               compare_field("found", exp_rsp.found, rsp_tdata[32]);
               compare_field("count", exp_rsp.count, rsp_tdata[33 +: CNT_W]);
               compare_field("status", exp_rsp.status, rsp_tdata[33 + CNT_W +: 2]);
            end
         end
         if (req_tvalid && req_tready)
            queued_results.push_back(deque_update(opcode_type'(req_tuser),
                                                  $signed(req_tdata)));
      end
      waiting = queued_results.size();
   end

endmodule

FILE: bench/circular_list_deque_with_search_tb.sv
// Testbench top for the circular deque with search: clock, reset, request
// stimulus, response back-pressure, watchdog and verdict.
// Depends on cldq_pkg, circular_list_deque_with_search and cldq_result_check.
`timescale 1ns / 1ps

module circular_list_deque_with_search_tb;
   import cldq_pkg::*;

   localparam int DEPTH      = 16;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int RSP_W      = ((35 + CNT_W + 7) / 8) * 8;
   localparam int QUIET_MAX  = 4000;
   localparam int PHASE_ITEMS = 235;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [1:0]       req_tuser;   // [1:0] opcode
   logic [31:0]      req_tdata;   // [31:0] value
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // head_value, found, count, status

   int unsigned mismatch_count;
   int unsigned outstanding;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int unsigned quiet_cycles = 0;

   // Recently inserted values, reused so that searches hit
   logic [31:0] value_pool [16];
   int unsigned pool_wr = 0;

   circular_list_deque_with_search #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cldq_result_check #(.DEPTH(DEPTH)) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Randomly stall the response channel
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   // End the run when nothing has been transferred for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Offer one request, with random idle cycles first, and hold it until transfer
   task automatic send_req(input opcode_type op, input logic [31:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tuser  = 2'($urandom_range(3));
         req_tdata  = $urandom();
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = val;
      if (op == OP_INS_FRONT || op == OP_INS_TAIL) begin
         value_pool[pool_wr] = val;
         pool_wr = (pool_wr + 1) % 16;
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(9);
      case (r)
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5, 6: return value_pool[$urandom_range(15)];
         default: return $urandom();
      endcase
   endfunction

   // Bursts that fill, drain or mix, so the ring reaches both full and empty
   task automatic run_random(input int n_items);
      int         i;
      int         burst_left;
      int         mode;
      int         r;
      opcode_type op;
      burst_left = 0;
      mode       = 0;
      for (i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            mode       = $urandom_range(2);
            burst_left = $urandom_range(30, 8);
         end
         burst_left--;
         r = $urandom_range(99);
         case (mode)
            0:       op = (r < 80) ? (r[0] ? OP_INS_TAIL : OP_INS_FRONT)
                                   : (r < 90) ? OP_SEARCH : OP_POP;
            1:       op = (r < 70) ? OP_POP : (r < 85) ? OP_SEARCH
                                   : (r[0] ? OP_INS_TAIL : OP_INS_FRONT);
            default: op = opcode_type'($urandom_range(3));
         endcase
         send_req(op, pick_value());
      end
   endtask

   initial begin : stimulus
      int i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_INS_FRONT;
      req_tdata  = 32'h0;
      for (i = 0; i < 16; i++) value_pool[i] = 32'h0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty cases, extremes, search hitting the tail, full ring
      send_req(OP_POP, 32'h0);
      send_req(OP_SEARCH, 32'hFFFF_FFFF);
      send_req(OP_INS_FRONT, 32'h8000_0000);
      send_req(OP_INS_TAIL, 32'h7FFF_FFFF);
      send_req(OP_SEARCH, 32'h7FFF_FFFF);
      send_req(OP_SEARCH, 32'h8000_0000);
      send_req(OP_SEARCH, 32'h0000_0001);
      for (i = 0; i < 13; i++)
         send_req(i[0] ? OP_INS_TAIL : OP_INS_FRONT, $urandom());
      send_req(OP_INS_TAIL, 32'h5A5A_A5A5);
      send_req(OP_INS_FRONT, 32'h1234_5678);
      send_req(OP_INS_TAIL, 32'h1234_5678);
      send_req(OP_SEARCH, 32'h5A5A_A5A5);

      // Random phases with different idle and stall pressure
      run_random(PHASE_ITEMS);
      send_idle_pct = 55;
      run_random(PHASE_ITEMS);
      send_idle_pct = 0;
      stall_pct     = 55;
      run_random(PHASE_ITEMS);
      send_idle_pct = 16;
      stall_pct     = 16;
      run_random(PHASE_ITEMS);

      @(negedge clock);
      req_tvalid = 1'b0;

      // Drain, then watch for stray responses
      while (outstanding != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
